// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg: shared types for the LFU cache
// Request and response payloads and widths that are fixed by the interface.
// ----------------------------------------------------------------------------
package lfu_pkg;
   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 31;
   localparam int CAP_BITS  = 5;

   typedef enum logic {
      MODE_GET = 1'b0,
      MODE_PUT = 1'b1
   } mode_type;

   typedef struct packed {
      logic                 mode;
      logic [KEY_BITS-1:0]  key;
      logic [DATA_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [DATA_BITS-1:0] data;
      logic                 evicted;
   } rsp_type;
endpackage

// ===== rtl/lfu_req_if.sv =====
// ----------------------------------------------------------------------------
// lfu_req_if: request channel
// Valid/ready channel carrying one cache request item.
// ----------------------------------------------------------------------------
interface lfu_req_if;
   logic              valid;
   logic              ready;
   lfu_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lfu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfu_rsp_if: response channel
// Valid/ready channel carrying one cache response item.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
   logic              valid;
   logic              ready;
   lfu_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lfu_cache_lru_tiebreak_unit.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_unit: LFU cache with LRU tie break
// Fully associative key/value cache; keys, counts and ranks live in per-entry
// registers for the parallel match, data in a synchronous memory with one
// write and one read port.
// ----------------------------------------------------------------------------
// A request is accepted in ST_IDLE and passes ST_MATCH (match/victim pass),
// ST_READ (data memory read) and ST_RESP, which loads the registered response
// when the output is free; no new request is accepted until then.
// Reset: all entries invalid, capacity 16; memory contents undefined.
module lfu_cache_lru_tiebreak_unit #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lfu_pkg::CAP_BITS-1:0]    csr_wr_data,
   lfu_req_if.sink                         req,
   lfu_rsp_if.source                       rsp
);
   import lfu_pkg::*;

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_BITS = $clog2(ENTRIES + 1);
   localparam int VKEY_BITS = COUNT_BITS + IDX_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MATCH = 4'b0010,
      ST_READ  = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CAP_BITS-1:0]   cap_ff;
   req_type               req_ff;
   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [COUNT_BITS-1:0] count_ff [ENTRIES];
   logic [IDX_BITS-1:0]   rank_ff  [ENTRIES];
   logic [OCC_BITS-1:0]   occ_ff;
   logic                  hit_ff, ev_ff;
   logic [IDX_BITS-1:0]   slot_ff;
   logic [IDX_BITS-1:0]   slot_in;
   logic                  hit_in, ev_in, do_touch, do_ins;
   logic [DATA_BITS-1:0]  rd_data;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_load;
   logic                  wr_en;
   logic [OCC_BITS-1:0]   cap_eff;

   assign cap_eff = (int'(cap_ff) > ENTRIES) ? OCC_BITS'(ENTRIES)
                                             : OCC_BITS'(cap_ff);

   // Match and free-slot search on the registered request.
   logic                 m_found, v_found, f_found;
   logic [IDX_BITS-1:0]  m_idx, v_idx, f_idx;
   always_comb begin
      m_found = 1'b0; m_idx = '0;
      f_found = 1'b0; f_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_ff[i] && key_ff[i] == req_ff.key && !m_found) begin
            m_found = 1'b1; m_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i] && !f_found) begin
            f_found = 1'b1; f_idx = IDX_BITS'(i);
         end
      end
   end

   // Victim: minimum of {count, rank} over valid entries, reduced as a tree.
   // Ranks are distinct among valid entries, so the minimum is unique.
   logic                 vt_ok  [2*ENTRIES];
   logic [VKEY_BITS-1:0] vt_key [2*ENTRIES];
   logic [IDX_BITS-1:0]  vt_idx [2*ENTRIES];
   always_comb begin
      for (int i = 0; i < 2*ENTRIES; i++) begin
         vt_ok[i] = 1'b0; vt_key[i] = '0; vt_idx[i] = '0;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         vt_ok[ENTRIES+i]  = valid_ff[i];
         vt_key[ENTRIES+i] = {count_ff[i], rank_ff[i]};
         vt_idx[ENTRIES+i] = IDX_BITS'(i);
      end
      for (int i = ENTRIES - 1; i >= 1; i--) begin
         if (vt_ok[2*i] && (!vt_ok[2*i+1] || vt_key[2*i] <= vt_key[2*i+1])) begin
            vt_ok[i] = 1'b1; vt_key[i] = vt_key[2*i]; vt_idx[i] = vt_idx[2*i];
         end else begin
            vt_ok[i] = vt_ok[2*i+1]; vt_key[i] = vt_key[2*i+1];
            vt_idx[i] = vt_idx[2*i+1];
         end
      end
      v_found = vt_ok[1];
      v_idx   = vt_idx[1];
   end

   always_comb begin
      hit_in = m_found;
      ev_in = 1'b0; do_touch = 1'b0; do_ins = 1'b0;
      slot_in = m_idx;
      if (m_found) begin
         do_touch = (req_ff.mode == MODE_GET) || (cap_eff != '0);
      end else if (req_ff.mode == MODE_PUT && cap_eff != '0) begin
         do_ins = 1'b1;
         if (occ_ff >= cap_eff && v_found) begin
            ev_in = 1'b1; slot_in = v_idx;
         end else begin
            slot_in = f_idx;
         end
      end
   end

   assign wr_en = (state_ff == ST_MATCH) &&
                  ((do_touch && req_ff.mode == MODE_PUT) || do_ins);

   lfu_entry_ram #(.ENTRIES(ENTRIES), .IDX_BITS(IDX_BITS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_in),
      .wr_data (req_ff.value),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req.valid) state_in = ST_MATCH;
         ST_MATCH: state_in = ST_READ;
         ST_READ:  state_in = ST_RESP;
         ST_RESP:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_BITS'(16);
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE && req.valid) req_ff <= req.payload;
         if (state_ff == ST_MATCH) begin
            hit_ff  <= hit_in;
            ev_ff   <= ev_in;
            slot_ff <= slot_in;
            if (do_touch) begin
               if (count_ff[m_idx] != COUNT_MAX)
                  count_ff[m_idx] <= count_ff[m_idx] + 1'b1;
               for (int i = 0; i < ENTRIES; i++)
                  if (valid_ff[i] && rank_ff[i] > rank_ff[m_idx])
                     rank_ff[i] <= rank_ff[i] - 1'b1;
               rank_ff[m_idx] <= IDX_BITS'(occ_ff - 1'b1);
            end else if (do_ins) begin
               key_ff[slot_in]   <= req_ff.key;
               count_ff[slot_in] <= COUNT_BITS'(1);
               valid_ff[slot_in] <= 1'b1;
               if (ev_in) begin
                  // victim's rank leaves; new entry takes the top rank
                  for (int i = 0; i < ENTRIES; i++)
                     if (valid_ff[i] && rank_ff[i] > rank_ff[v_idx])
                        rank_ff[i] <= rank_ff[i] - 1'b1;
                  rank_ff[slot_in] <= IDX_BITS'(occ_ff - 1'b1);
               end else begin
                  rank_ff[slot_in] <= IDX_BITS'(occ_ff);
                  occ_ff <= occ_ff + 1'b1;
               end
            end
         end
         if (rsp_load) begin
            rsp_ff.hit     <= hit_ff;
            rsp_ff.evicted <= ev_ff;
            rsp_ff.data    <= (hit_ff && req_ff.mode == MODE_GET) ? rd_data : '0;
         end
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_BITS'(ENTRIES)) else $error("occupancy overflow");
   a_occ_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff)) else $error("occupancy mismatch");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_ev_put: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.payload.evicted) |-> !rsp.payload.hit)
      else $error("eviction on hit");
endmodule

// ===== rtl/lfu_entry_ram.sv =====
// ----------------------------------------------------------------------------
// lfu_entry_ram: entry payload memory
// Holds the data of each entry; one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfu_entry_ram #(
   parameter int ENTRIES = 16,
   parameter int IDX_BITS = 4
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [IDX_BITS-1:0]           wr_addr,
   input  logic [lfu_pkg::DATA_BITS-1:0] wr_data,
   input  logic [IDX_BITS-1:0]           rd_addr,
   output logic [lfu_pkg::DATA_BITS-1:0] rd_data
);
   import lfu_pkg::*;

   logic [DATA_BITS-1:0] data_mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_mem[wr_addr] <= wr_data;
      end
      rd_data <= data_mem[rd_addr];
   end
endmodule

// ===== dv/tb_lfu_cache_lru_tiebreak_unit.sv =====
// ----------------------------------------------------------------------------
// LFU cache with LRU tie break: self-checking testbench
// Drives get/put items with random gaps, predicts each response from a local
// model of the cache (count, recency, eviction) and compares field by field.
// ----------------------------------------------------------------------------
module tb_lfu_cache_lru_tiebreak_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import lfu_pkg::*;

   localparam int SLOTS     = 16;
   localparam int CNT_MAX   = 65535;
   localparam int LATENCY   = 4;
   localparam int IDLE_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CAP_BITS-1:0] csr_wr_data = '0;

   lfu_req_if req ();
   lfu_rsp_if rsp ();

   lfu_cache_lru_tiebreak_unit dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data), .req(req.sink), .rsp(rsp.source)
   );

   always #4 clock = ~clock;

   // cache model
   bit                 m_valid [SLOTS];
   bit [KEY_BITS-1:0]  m_key   [SLOTS];
   bit [DATA_BITS-1:0] m_data  [SLOTS];
   int unsigned        m_count [SLOTS];
   int unsigned        m_rank  [SLOTS];
   int unsigned        m_occupied;
   int unsigned        m_capacity;

   req_type pending_items[$];
   rsp_type expected_rsps[$];
   int errors;
   bit sender_idle_en = 1'b1;
   bit recv_idle_en = 1'b1;
   bit req_taken = 1'b0;
   int recv_hold_cycles = 0;
   int send_gap, recv_gap;
   int quiet_cycles;
   int n_sent, n_seen;

   function automatic void close_gap(int unsigned r);
      for (int i = 0; i < SLOTS; i++)
         if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
   endfunction

   function automatic void touch_slot(int s);
      if (m_count[s] < CNT_MAX) m_count[s]++;
      close_gap(m_rank[s]);
      m_rank[s] = m_occupied - 1;
   endfunction

   function automatic rsp_type predict_access(req_type it);
      rsp_type r;
      int s, slot, cap;
      s = -1;
      slot = -1;
      r = '0;
      cap = (m_capacity > SLOTS) ? SLOTS : m_capacity;
      for (int i = 0; i < SLOTS; i++)
         if (s < 0 && m_valid[i] && m_key[i] == it.key) s = i;
      r.hit = (s >= 0);
      if (it.mode == MODE_GET) begin
         if (s >= 0) begin
            r.data = m_data[s];
            touch_slot(s);
         end
      end else if (cap != 0) begin
         if (s >= 0) begin
            touch_slot(s);
            m_data[s] = it.value;
         end else begin
            if (m_occupied >= cap) begin
               for (int i = 0; i < SLOTS; i++)
                  if (m_valid[i] && (slot < 0 || m_count[i] < m_count[slot] ||
                      (m_count[i] == m_count[slot] && m_rank[i] < m_rank[slot])))
                     slot = i;
               if (slot >= 0) begin
                  m_valid[slot] = 1'b0;
                  close_gap(m_rank[slot]);
                  m_occupied--;
                  r.evicted = 1'b1;
               end
            end
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && !m_valid[i]) slot = i;
            if (slot >= 0) begin
               m_valid[slot] = 1'b1;
               m_key[slot] = it.key;
               m_data[slot] = it.value;
               m_count[slot] = 1;
               m_rank[slot] = m_occupied;
               m_occupied++;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch on response %0d: %s got %0h expected %0h", n_seen, what, got, want);
   endtask

   // driver: predict on accept, advance at the falling edge
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         expected_rsps.insert(expected_rsps.size(), predict_access(req.payload));
         pending_items.delete(0);
         req_taken = 1'b1;
         n_sent++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !req_taken) begin
         // hold the offered item until it is accepted
      end else begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req.valid <= 1'b0;
         end else if (sender_idle_en && pending_items.size() > 0 &&
                      $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 4);
            req.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req.valid <= 1'b1;
            req.payload <= pending_items[0];
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = expected_rsps[0];
            expected_rsps.delete(0);
            if (rsp.payload.hit !== want.hit)
               report_mismatch("hit", rsp.payload.hit, want.hit);
            if (rsp.payload.data !== want.data)
               report_mismatch("data", rsp.payload.data, want.data);
            if (rsp.payload.evicted !== want.evicted)
               report_mismatch("evicted", rsp.payload.evicted, want.evicted);
         end
         n_seen++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (recv_hold_cycles > 0) begin
         // long stall: hold off the receiver
         recv_hold_cycles--;
         rsp.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp.ready <= 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(0, 4);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_item(mode_type md, logic [KEY_BITS-1:0] k, logic [DATA_BITS-1:0] v);
      req_type it;
      it.mode = md;
      it.key = k;
      it.value = v;
      pending_items.insert(pending_items.size(), it);
   endtask

   task automatic drain();
      wait (pending_items.size() == 0 && expected_rsps.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_capacity(int unsigned c);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= c[CAP_BITS-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      m_capacity = c & 5'h1f;
   endtask

   // well-formed traffic: keys from a small pool so hits and evictions happen
   task automatic add_random(int n, int pool);
      logic [KEY_BITS-1:0] k;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) k = $urandom();
         else k = 32'h8000_0000 ^ $urandom_range(0, pool - 1);
         add_item($urandom_range(0, 1) ? MODE_PUT : MODE_GET, k, DATA_BITS'($urandom()));
      end
   endtask

   initial begin
      int caps[6] = '{4, 1, 0, 31, 8, 16};
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      m_occupied = 0;
      m_capacity = 16;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, update, eviction tie, gets miss/hit
      add_item(MODE_GET, 32'h0, 31'h0);
      add_item(MODE_PUT, 32'h8000_0000, 31'h7fff_ffff);
      add_item(MODE_PUT, 32'h7fff_ffff, 31'h0);
      add_item(MODE_PUT, 32'hffff_ffff, 31'h5555_5555);
      add_item(MODE_PUT, 32'h0, 31'h2aaa_aaaa);
      add_item(MODE_GET, 32'h8000_0000, 31'h7fff_ffff);
      add_item(MODE_PUT, 32'h7fff_ffff, 31'h1234);
      add_item(MODE_GET, 32'h7fff_ffff, 31'h0);
      add_item(MODE_GET, 32'h1, 31'h0);
      drain();
      set_capacity(2);
      // below occupancy: each new key evicts one
      add_item(MODE_PUT, 32'h10, 31'h10);
      add_item(MODE_PUT, 32'h11, 31'h11);
      add_item(MODE_GET, 32'h10, 31'h0);
      add_item(MODE_PUT, 32'h12, 31'h12);
      drain();
      // raise a use count with repeated gets
      set_capacity(16);
      for (int i = 0; i < 70; i++) add_item(MODE_GET, 32'h12, 31'h0);
      drain();

      // long receiver stall while the sender keeps offering
      recv_hold_cycles = 120;
      add_random(20, 24);
      wait (recv_hold_cycles == 0);
      drain();

      foreach (caps[c]) begin
         set_capacity(caps[c]);
         add_random(250, (c % 2) ? 12 : 40);
         drain();
      end
      set_capacity(3);
      sender_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      add_random(150, 10);
      drain();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
